// ----- hdl/sorted_record_table_binary_search_assert.svh -----
// Assertion macros shared by the checker of the record table.
// Depends on nothing; included by the checker file.
`ifndef SORTED_RECORD_TABLE_BINARY_SEARCH_ASSERT_SVH
`define SORTED_RECORD_TABLE_BINARY_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRTBS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRTBS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/srtbs_pkg.sv -----
// Package for the sorted record table: sizes, codes and the control types.
// Depends on nothing; used by all files but srtbs_ram and the .svh header.
`timescale 1ns / 1ps

package srtbs_pkg;

  localparam int TABLE_DEPTH     = 1024;
  localparam int PAYLOAD_BITS    = 64;
  localparam int ADDR_W          = $clog2(TABLE_DEPTH);
  localparam int COUNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W            = 32;
  localparam int PAYLOAD_FIELD_W = 64;
  localparam int POS_W           = 10;
  localparam int FUNC_W          = 2;
  localparam int STATUS_W        = 2;

  localparam logic [FUNC_W-1:0] FUNC_STORE    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET      = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    RES_STORED,
    RES_FULL,
    RES_MISS,
    RES_HIT
  } res_kind_t;

  typedef struct packed {
    logic      load_req;
    logic      probe_en;
    logic      step;
    logic      store_wr;
    logic      update_wr;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } srtbs_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func_in;
    logic [FUNC_W-1:0] func_q;
    logic              full;
    logic              range_cur;
    logic              range_step;
    logic              hit;
  } srtbs_sts_t;

endpackage

// ----- hdl/srtbs_req_if.sv -----
// Request channel of the record table: handshake plus operation fields.
// Depends on srtbs_pkg.
`timescale 1ns / 1ps

interface srtbs_req_if
  import srtbs_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic [ID_W-1:0]            record_id;
  logic [PAYLOAD_FIELD_W-1:0] record_payload;

  modport source (output valid, func, record_id, record_payload, input ready);
  modport sink (input valid, func, record_id, record_payload, output ready);
endinterface

// ----- hdl/srtbs_rsp_if.sv -----
// Response channel of the record table: handshake plus result fields.
// Depends on srtbs_pkg.
`timescale 1ns / 1ps

interface srtbs_rsp_if
  import srtbs_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [PAYLOAD_FIELD_W-1:0] found_payload;
  logic [POS_W-1:0]           found_position;

  modport source (output valid, status, found_payload, found_position, input ready);
  modport sink (input valid, status, found_payload, found_position, output ready);
endinterface

// ----- hdl/srtbs_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module srtbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/srtbs_ctrl.sv -----
// Controller of the record table: sequences store, search and response.
// Depends on srtbs_pkg; drives the datapath through srtbs_cmd_t.
`timescale 1ns / 1ps

module srtbs_ctrl
  import srtbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  srtbs_sts_t sts,
  output srtbs_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_START,
    S_LOOK,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          unique case (sts.func_in)
            FUNC_STORE: begin
              if (sts.full) begin
                cmd.res_load = 1'b1;
                cmd.res_kind = RES_FULL;
                state_next   = S_RESULT;
              end else begin
                state_next = S_STORE;
              end
            end
            FUNC_GET, FUNC_UPDATE: begin
              state_next = S_START;
            end
            default: begin
              cmd.res_load = 1'b1;
              cmd.res_kind = RES_MISS;
              state_next   = S_RESULT;
            end
          endcase
        end
      end
      S_STORE: begin
        cmd.store_wr = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_STORED;
        state_next   = S_RESULT;
      end
      S_START: begin
        if (sts.range_cur) begin
          cmd.probe_en = 1'b1;
          state_next   = S_LOOK;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_MISS;
          state_next   = S_RESULT;
        end
      end
      S_LOOK: begin
        if (sts.hit) begin
          cmd.res_load  = 1'b1;
          cmd.res_kind  = RES_HIT;
          cmd.update_wr = (sts.func_q == FUNC_UPDATE);
          state_next    = S_RESULT;
        end else begin
          cmd.step = 1'b1;
          if (sts.range_step) begin
            cmd.probe_en = 1'b1;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_MISS;
            state_next   = S_RESULT;
          end
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/srtbs_dpath.sv -----
// Datapath of the record table: id and payload memories, fill count,
// search bounds, result and output registers. Depends on srtbs_pkg, srtbs_ram.
`timescale 1ns / 1ps

module srtbs_dpath
  import srtbs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  srtbs_cmd_t                 cmd,
  output srtbs_sts_t                 sts,
  input  logic [FUNC_W-1:0]          req_func,
  input  logic [ID_W-1:0]            req_id,
  input  logic [PAYLOAD_FIELD_W-1:0] req_payload,
  output logic [STATUS_W-1:0]        out_status,
  output logic [PAYLOAD_FIELD_W-1:0] out_payload,
  output logic [POS_W-1:0]           out_position
);

  logic [COUNT_W-1:0]         fill_count;
  logic [FUNC_W-1:0]          func_q;
  logic [ID_W-1:0]            key_q;
  logic [PAYLOAD_BITS-1:0]    pay_q;
  logic [COUNT_W-1:0]         lo;
  logic [COUNT_W-1:0]         hi1;
  logic [ADDR_W-1:0]          mid_q;
  logic [COUNT_W-1:0]         lo_step;
  logic [COUNT_W-1:0]         hi1_step;
  logic [COUNT_W-1:0]         mid_cur;
  logic [COUNT_W-1:0]         mid_step;
  logic [ADDR_W-1:0]          probe_addr;
  logic [ID_W-1:0]            rd_id;
  logic [PAYLOAD_BITS-1:0]    rd_pay;
  logic                       less;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [STATUS_W-1:0]        res_status;
  logic [PAYLOAD_FIELD_W-1:0] res_payload;
  logic [POS_W-1:0]           res_position;

  // Bounds are kept as [lo, hi1) so that no negative value is needed.
  assign less     = rd_id < key_q;
  assign lo_step  = less ? (COUNT_W'(mid_q) + COUNT_W'(1)) : lo;
  assign hi1_step = less ? hi1 : COUNT_W'(mid_q);
  assign mid_cur  = lo + ((hi1 - lo - COUNT_W'(1)) >> 1);
  assign mid_step = lo_step + ((hi1_step - lo_step - COUNT_W'(1)) >> 1);
  assign probe_addr = cmd.step ? mid_step[ADDR_W-1:0] : mid_cur[ADDR_W-1:0];

  assign sts.func_in    = req_func;
  assign sts.func_q     = func_q;
  assign sts.full       = (fill_count == COUNT_W'(TABLE_DEPTH));
  assign sts.range_cur  = lo < hi1;
  assign sts.range_step = lo_step < hi1_step;
  assign sts.hit        = (rd_id == key_q);

  assign wr_en   = cmd.store_wr || cmd.update_wr;
  assign wr_addr = cmd.store_wr ? fill_count[ADDR_W-1:0] : mid_q;

  srtbs_ram #(
    .WIDTH(ID_W),
    .DEPTH(TABLE_DEPTH)
  ) u_id_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(key_q),
    .re   (cmd.probe_en),
    .raddr(probe_addr),
    .rdata(rd_id)
  );

  srtbs_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_pay_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(pay_q),
    .re   (cmd.probe_en),
    .raddr(probe_addr),
    .rdata(rd_pay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.store_wr) begin
      fill_count <= fill_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      func_q <= req_func;
      key_q  <= req_id;
      pay_q  <= req_payload[PAYLOAD_BITS-1:0];
      lo     <= '0;
      hi1    <= fill_count;
    end else if (cmd.step) begin
      lo  <= lo_step;
      hi1 <= hi1_step;
    end
    if (cmd.probe_en) begin
      mid_q <= probe_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        RES_STORED: begin
          res_status   <= STATUS_DONE;
          res_payload  <= '0;
          res_position <= POS_W'(fill_count[ADDR_W-1:0]);
        end
        RES_FULL: begin
          res_status   <= STATUS_FULL;
          res_payload  <= '0;
          res_position <= '0;
        end
        RES_MISS: begin
          res_status   <= STATUS_MISS;
          res_payload  <= '0;
          res_position <= '0;
        end
        RES_HIT: begin
          res_status   <= STATUS_DONE;
          res_payload  <= (func_q == FUNC_GET) ? PAYLOAD_FIELD_W'(rd_pay) : '0;
          res_position <= POS_W'(mid_q);
        end
        default: begin
          res_status   <= STATUS_MISS;
          res_payload  <= '0;
          res_position <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status   <= res_status;
      out_payload  <= res_payload;
      out_position <= res_position;
    end
  end

endmodule

// ----- hdl/sorted_record_table_binary_search.sv -----
// Sorted record table with binary-search lookup.
// Depends on srtbs_pkg, srtbs_req_if, srtbs_rsp_if, srtbs_ctrl and srtbs_dpath.
//
// The req channel carries one transaction per operation: func selects store
// (append at the fill count), get by id or update by id, with record_id and
// record_payload. The rsp channel returns exactly one transaction per request
// with status, found_payload and found_position.
// One operation is in flight at a time. After the accepting edge a store
// passes through the store state to the result state; a store into a full
// table, or an unused func code, goes straight to the result state. Get and
// update pass through the start state and then the lookup state once per
// probe of the search; a table of N entries needs at most floor(log2 N)+1
// probes. The probe loop runs one memory read per cycle. The next request is
// taken in the cycle after the response is loaded into the output register.
// A synchronous reset clears the fill count and the handshake state; the
// table contents are not cleared and are only read below the fill count.
// When the receiver stalls, the response holds and the block finishes at
// most one further operation before it waits.
`timescale 1ns / 1ps

module sorted_record_table_binary_search
  import srtbs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  srtbs_req_if.sink   req,
  srtbs_rsp_if.source rsp
);

  srtbs_cmd_t cmd;
  srtbs_sts_t sts;

  srtbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srtbs_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_func    (req.func),
    .req_id      (req.record_id),
    .req_payload (req.record_payload),
    .out_status  (rsp.status),
    .out_payload (rsp.found_payload),
    .out_position(rsp.found_position)
  );

endmodule

// ----- hdl/srtbs_checker.sv -----
// Port-level checks for the record table, attached to the top level by bind.
// Depends on srtbs_pkg and sorted_record_table_binary_search_assert.svh.
`timescale 1ns / 1ps
`include "sorted_record_table_binary_search_assert.svh"

module srtbs_checker
  import srtbs_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [STATUS_W-1:0]        status,
  input logic [PAYLOAD_FIELD_W-1:0] found_payload,
  input logic [POS_W-1:0]           found_position
);

  logic status_ok;
  logic fail_rsp;
  logic fields_zero;

  assign status_ok   = (status == STATUS_DONE) || (status == STATUS_MISS) ||
                       (status == STATUS_FULL);
  assign fail_rsp    = rsp_valid && (status != STATUS_DONE);
  assign fields_zero = (found_payload == '0) && (found_position == '0);

  `SRTBS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
  `SRTBS_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready, "req overlap")
  `SRTBS_ASSERT_NOW(a_status_code, clk, rst, rsp_valid, status_ok, "bad status code")
  `SRTBS_ASSERT_NOW(a_fail_zero, clk, rst, fail_rsp, fields_zero, "fields not zero on failure")

endmodule

bind sorted_record_table_binary_search srtbs_checker u_srtbs_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .found_payload (rsp.found_payload),
  .found_position(rsp.found_position)
);

// ----- tb/sorted_record_table_binary_search_checker.sv -----
// Checker for the sorted record table: watches the request and response channels,
// predicts each response and compares it field by field.
// Depends on srtbs_pkg, srtbs_req_if and srtbs_rsp_if.
`timescale 1ns / 1ps

module sorted_record_table_binary_search_checker
  import srtbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  srtbs_req_if  req,
  srtbs_rsp_if  rsp,
  output int    errors,
  output int    pending
);

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [PAYLOAD_FIELD_W-1:0] payload;
    logic [POS_W-1:0]           position;
  } table_result_t;

  logic [ID_W-1:0]         model_ids [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] model_payloads [TABLE_DEPTH];
  int unsigned             model_fill;
  table_result_t           awaited[$];

  function automatic table_result_t perform_operation(input logic [FUNC_W-1:0] func,
                                                     input logic [ID_W-1:0] key,
                                                     input logic [PAYLOAD_FIELD_W-1:0] data);
    table_result_t r;
    int lo;
    int hi;
    int mid;
    logic hit;
    r = '0;
    r.status = STATUS_MISS;
    mid = 0;
    hit = 1'b0;
    case (func)
      FUNC_STORE: begin
        if (model_fill >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          model_ids[model_fill] = key;
          model_payloads[model_fill] = data[PAYLOAD_BITS-1:0];
          r.status = STATUS_DONE;
          r.position = POS_W'(model_fill);
          model_fill++;
        end
      end
      FUNC_GET, FUNC_UPDATE: begin
        lo = 0;
        hi = int'(model_fill) - 1;
        while (!hit && lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (model_ids[mid] == key) begin
            hit = 1'b1;
          end else if (model_ids[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        if (hit) begin
          r.status = STATUS_DONE;
          r.position = POS_W'(mid);
          if (func == FUNC_GET) begin
            r.payload = PAYLOAD_FIELD_W'(model_payloads[mid]);
          end else begin
            model_ids[mid] = key;
            model_payloads[mid] = data[PAYLOAD_BITS-1:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      model_fill = 0;
      awaited.delete();
      errors = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited.size() == 0) begin
          errors++;
          $display("%0t: status expected none actual %h", $time, rsp.status);
        end else begin
          want = awaited.pop_front();
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("found_payload", want.payload, rsp.found_payload);
          check_field("found_position", 64'(want.position), 64'(rsp.found_position));
        end
      end
      if (req.valid && req.ready) begin
        awaited = {awaited, perform_operation(req.func, req.record_id, req.record_payload)};
      end
    end
    pending = awaited.size();
  end

endmodule

// ----- tb/sorted_record_table_binary_search_test.sv -----
// Top of the record table testbench: clock, reset, request and response stimulus
// and the verdict. Depends on srtbs_pkg, both channel interfaces, the block and
// sorted_record_table_binary_search_checker.
`timescale 1ns / 1ps

module sorted_record_table_binary_search_test;
  import srtbs_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  bit   idling;
  int   stall_left = 0;

  logic [ID_W-1:0] stored_ids[$];
  logic [ID_W-1:0] next_id;
  int              stored_count;

  srtbs_req_if req_ch ();
  srtbs_rsp_if rsp_ch ();

  sorted_record_table_binary_search i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_record_table_binary_search_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic issue(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] key,
                       input logic [PAYLOAD_FIELD_W-1:0] data);
    if (idling && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= func;
    req_ch.record_id <= key;
    req_ch.record_payload <= data;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic store_record(input logic [ID_W-1:0] key,
                              input logic [PAYLOAD_FIELD_W-1:0] data);
    if (stored_count < TABLE_DEPTH) begin
      stored_ids = {stored_ids, key};
      stored_count++;
    end
    issue(FUNC_STORE, key, data);
  endtask

  function automatic logic [ID_W-1:0] pick_key();
    if (stored_ids.size() != 0 && $urandom_range(0, 4) != 0) begin
      return stored_ids[$urandom_range(0, stored_ids.size() - 1)];
    end
    return $urandom;
  endfunction

  task automatic random_operation();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      store_record($urandom, {$urandom, $urandom});
    end else if (r < 40) begin
      next_id = next_id + $urandom_range(0, 1 << 21);
      store_record(next_id, {$urandom, $urandom});
    end else if (r < 70) begin
      issue(FUNC_GET, pick_key(), {$urandom, $urandom});
    end else if (r < 96) begin
      issue(FUNC_UPDATE, pick_key(), {$urandom, $urandom});
    end else begin
      issue(FUNC_RESERVED, $urandom, {$urandom, $urandom});
    end
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.func <= FUNC_STORE;
    req_ch.record_id <= '0;
    req_ch.record_payload <= '0;
    idling = 1'b1;
    stored_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed transactions: empty table, unused code, extremes and hits.
    issue(FUNC_GET, 32'h0, 64'h0);
    issue(FUNC_UPDATE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(FUNC_RESERVED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    store_record(32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(FUNC_GET, 32'h0, 64'h0);
    issue(FUNC_GET, 32'h1, 64'h0);
    store_record(32'd100, 64'h0);
    store_record(32'h0000_1000, 64'h0123_4567_89AB_CDEF);
    issue(FUNC_GET, 32'd100, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(FUNC_UPDATE, 32'd100, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(FUNC_GET, 32'd100, 64'h0);
    issue(FUNC_GET, 32'h0000_1000, 64'h0);
    issue(FUNC_UPDATE, 32'hFFFF_FFFF, 64'h0);
    issue(FUNC_GET, 32'hFFFF_FFFF, 64'h0);
    issue(FUNC_UPDATE, 32'h0, 64'h0);
    issue(FUNC_GET, 32'h0, 64'h0);
    issue(FUNC_RESERVED, 32'h0, 64'h0);
    next_id = 32'h0000_1000;

    for (int i = 0; i < 420; i++) begin
      idling = ((i / 60) % 2) == 0;
      random_operation();
    end

    idling = 1'b0;
    for (int i = 0; i < 60; i++) begin
      random_operation();
    end
    req_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_record_table_binary_search_test: done, clean");
    end else begin
      $display("sorted_record_table_binary_search_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("sorted_record_table_binary_search_test: done, errors");
    $finish;
  end

endmodule

// ----- sorted_record_table_binary_search.f -----
+incdir+hdl
hdl/srtbs_pkg.sv
hdl/srtbs_req_if.sv
hdl/srtbs_rsp_if.sv
hdl/srtbs_ram.sv
hdl/srtbs_ctrl.sv
hdl/srtbs_dpath.sv
hdl/sorted_record_table_binary_search.sv
hdl/srtbs_checker.sv
tb/sorted_record_table_binary_search_checker.sv
tb/sorted_record_table_binary_search_test.sv
